// ===== design/pyro_pkg.sv =====
// ----------------------------------------------------------------------------
// Release actuator controller package
// Shared types, register indexes, function codes and fixed thresholds.
// ----------------------------------------------------------------------------
package pyro_pkg;

	localparam int TIME_BITS = 32;
	localparam int PERIOD_W = 31;
	localparam int CMP_W = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

	localparam logic [15:0] ARM_SHORT_MV = 16'd5000;
	localparam logic [15:0] ARMED_NO_RELEASE_MV = 16'd18000;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [2:0] {
		FN_FIRE     = 3'd0,
		FN_SELFTEST = 3'd1,
		FN_ARM      = 3'd2,
		FN_DISARM   = 3'd3,
		FN_STATUS   = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		RC_RUNNING     = 3'd0,
		RC_PASSED      = 3'd1,
		RC_NO_BATTERY  = 3'd2,
		RC_LOW_BATTERY = 3'd3,
		RC_SHORT       = 3'd4,
		RC_OPEN        = 3'd5,
		RC_NO_RELEASE  = 3'd6
	} rc_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TEST_WAIT = 3'd1,
		PH_FIRE_WAIT = 3'd2,
		PH_FIRE_ON   = 3'd3,
		PH_OFF_WAIT  = 3'd4,
		PH_FIRE_OFF  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		REG_EXPECTED_CODE = 3'd0,
		REG_HALF_PERIOD   = 3'd1,
		REG_FIRE_HOLD     = 3'd2,
		REG_SETTLE_DELAY  = 3'd3,
		REG_NO_BATTERY    = 3'd4,
		REG_LOW_BATTERY   = 3'd5,
		REG_FAIL_OPEN     = 3'd6,
		REG_NO_RELEASE    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] now;
		logic [31:0] offered_code;
		logic        fire_monitor;
		logic        arm_sense;
		logic [15:0] test_volt_mv;
		logic [15:0] arm_volt_mv;
		logic [15:0] release_volt_mv;
	} req_t;

	typedef struct packed {
		logic       done_or_accepted;
		logic [2:0] result_code;
		logic       fire_drive;
		logic       test_drive;
		logic       arm_drive;
		logic       armed_in_test_fault;
	} res_t;

	typedef struct packed {
		logic [31:0]         expected_code;
		logic [PERIOD_W-1:0] half_period_cycles;
		logic [PERIOD_W-1:0] fire_hold_cycles;
		logic [PERIOD_W-1:0] settle_delay_cycles;
		logic [15:0]         no_battery_mv;
		logic [15:0]         low_battery_mv;
		logic [15:0]         fail_open_mv;
		logic [15:0]         no_release_test_mv;
	} cfg_t;

endpackage

// ===== design/pyro_cfg.sv =====
// ----------------------------------------------------------------------------
// Release actuator configuration registers
// Holds the safety code, timer periods and voltage thresholds.
// ----------------------------------------------------------------------------
module pyro_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output pyro_pkg::cfg_t cfg
);
	import pyro_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_code <= 32'd0;
			cfg_q.half_period_cycles <= PERIOD_W'(200);
			cfg_q.fire_hold_cycles <= PERIOD_W'(3000000);
			cfg_q.settle_delay_cycles <= PERIOD_W'(100000);
			cfg_q.no_battery_mv <= 16'd5000;
			cfg_q.low_battery_mv <= 16'd24000;
			cfg_q.fail_open_mv <= 16'd500;
			cfg_q.no_release_test_mv <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_EXPECTED_CODE: cfg_q.expected_code <= cfg_data;
				REG_HALF_PERIOD: cfg_q.half_period_cycles <= cfg_data[PERIOD_W-1:0];
				REG_FIRE_HOLD: cfg_q.fire_hold_cycles <= cfg_data[PERIOD_W-1:0];
				REG_SETTLE_DELAY: cfg_q.settle_delay_cycles <= cfg_data[PERIOD_W-1:0];
				REG_NO_BATTERY: cfg_q.no_battery_mv <= cfg_data[15:0];
				REG_LOW_BATTERY: cfg_q.low_battery_mv <= cfg_data[15:0];
				REG_FAIL_OPEN: cfg_q.fail_open_mv <= cfg_data[15:0];
				REG_NO_RELEASE: cfg_q.no_release_test_mv <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/pyro_ctrl.sv =====
// ----------------------------------------------------------------------------
// Release actuator control state
// Fire pulsing, self-test sequence, arm and disarm, and armed status check.
// ----------------------------------------------------------------------------
module pyro_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  pyro_pkg::req_t req,
	input  pyro_pkg::cfg_t cfg,
	output pyro_pkg::res_t res
);
	import pyro_pkg::*;

	logic   fire_q, test_q, arm_q;
	time_t  last_toggle_q, fire_end_q, phase_start_q;
	phase_t phase_q;
	rc_t    verdict_q;

	logic   fire_d, test_d, arm_d;
	time_t  last_toggle_d, fire_end_d, phase_start_d;
	phase_t phase_d;
	rc_t    verdict_d;

	time_t  now_t, due, due_diff, end_diff, toggle_diff;
	logic   ge_due, ge_end, toggle_ok, code_ok, armed_block;
	rc_t    verdict_early, verdict_late, status_rc;
	func_t  func;

	assign func = func_t'(req.func);
	assign now_t = TIME_BITS'(req.now);
	assign due = phase_start_q + TIME_BITS'(cfg.settle_delay_cycles);
	assign due_diff = now_t - due;
	assign end_diff = now_t - fire_end_q;
	assign toggle_diff = now_t - last_toggle_q;
	assign ge_due = !due_diff[TIME_BITS-1];
	assign ge_end = !end_diff[TIME_BITS-1];
	assign toggle_ok = CMP_W'(toggle_diff) >= CMP_W'(cfg.half_period_cycles);
	assign code_ok = req.offered_code == cfg.expected_code;
	assign armed_block = (phase_q != PH_IDLE) && req.arm_sense;

	always_comb begin
		verdict_early = verdict_q;
		if (req.test_volt_mv < cfg.no_battery_mv) begin
			verdict_early = RC_NO_BATTERY;
		end else if (req.test_volt_mv < cfg.low_battery_mv) begin
			verdict_early = RC_LOW_BATTERY;
		end else if (req.arm_volt_mv < ARM_SHORT_MV) begin
			verdict_early = RC_SHORT;
		end

		verdict_late = verdict_q;
		if (req.release_volt_mv > cfg.fail_open_mv) begin
			verdict_late = RC_OPEN;
		end else if (req.arm_volt_mv > cfg.no_release_test_mv) begin
			verdict_late = RC_NO_RELEASE;
		end

		status_rc = RC_PASSED;
		if (req.fire_monitor) begin
			if (req.release_volt_mv > cfg.fail_open_mv) begin
				status_rc = RC_OPEN;
			end else if (req.arm_volt_mv > ARMED_NO_RELEASE_MV) begin
				status_rc = RC_NO_RELEASE;
			end
		end else begin
			if (req.arm_volt_mv < cfg.no_battery_mv) begin
				status_rc = RC_NO_BATTERY;
			end else if (req.arm_volt_mv < cfg.low_battery_mv) begin
				status_rc = RC_LOW_BATTERY;
			end
		end
	end

	// Self-test sequence next phase.
	always_comb begin
		phase_d = phase_q;
		if (func == FN_SELFTEST && !armed_block) begin
			case (phase_q)
				PH_TEST_WAIT: begin
					if (ge_due) begin
						phase_d = (verdict_early != RC_PASSED) ? PH_FIRE_OFF : PH_FIRE_WAIT;
					end
				end
				PH_FIRE_WAIT: begin
					if (req.fire_monitor) phase_d = PH_FIRE_ON;
				end
				PH_FIRE_ON: begin
					if (ge_due) phase_d = PH_OFF_WAIT;
				end
				PH_OFF_WAIT: begin
					if (!req.fire_monitor) phase_d = PH_FIRE_OFF;
				end
				PH_FIRE_OFF: begin
					if (ge_due) phase_d = PH_IDLE;
				end
				PH_IDLE: begin
					phase_d = req.arm_sense ? PH_IDLE : PH_TEST_WAIT;
				end
				default: begin
					phase_d = req.arm_sense ? PH_IDLE : PH_TEST_WAIT;
				end
			endcase
		end
	end

	// Drive levels, timers, verdict and result fields.
	always_comb begin
		fire_d = fire_q;
		test_d = test_q;
		arm_d = arm_q;
		last_toggle_d = last_toggle_q;
		fire_end_d = fire_end_q;
		phase_start_d = phase_start_q;
		verdict_d = verdict_q;
		res = '0;

		case (func)
			FN_FIRE: begin
				if (!req.fire_monitor) begin
					fire_end_d = now_t + TIME_BITS'(cfg.fire_hold_cycles);
					if (code_ok && toggle_ok) begin
						last_toggle_d = now_t;
						fire_d = !fire_q;
					end
				end else if (ge_end) begin
					fire_d = 1'b0;
					res.done_or_accepted = 1'b1;
				end else if (code_ok && toggle_ok) begin
					last_toggle_d = now_t;
					fire_d = !fire_q;
				end
			end
			FN_SELFTEST: begin
				if (armed_block) begin
					res.armed_in_test_fault = 1'b1;
				end else begin
					case (phase_q)
						PH_TEST_WAIT: begin
							if (ge_due) verdict_d = verdict_early;
						end
						PH_FIRE_WAIT: begin
							if (toggle_ok) begin
								last_toggle_d = now_t;
								fire_d = !fire_q;
							end
							if (req.fire_monitor) phase_start_d = now_t;
						end
						PH_FIRE_ON: begin
							if (toggle_ok) begin
								last_toggle_d = now_t;
								fire_d = !fire_q;
							end
							if (ge_due) verdict_d = verdict_late;
						end
						PH_OFF_WAIT: begin
							if (!req.fire_monitor) phase_start_d = now_t;
						end
						PH_FIRE_OFF: begin
							if (ge_due) begin
								test_d = 1'b0;
								res.result_code = verdict_q;
							end
						end
						default: begin
							if (!req.arm_sense) begin
								test_d = 1'b1;
								phase_start_d = now_t;
								verdict_d = RC_PASSED;
							end
						end
					endcase
				end
			end
			FN_ARM: begin
				if (!test_q) begin
					arm_d = 1'b1;
					res.done_or_accepted = 1'b1;
				end
			end
			FN_DISARM: begin
				if (!req.fire_monitor) begin
					arm_d = 1'b0;
					res.done_or_accepted = 1'b1;
				end
			end
			FN_STATUS: begin
				res.result_code = status_rc;
			end
			default: ;
		endcase

		res.fire_drive = fire_d;
		res.test_drive = test_d;
		res.arm_drive = arm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_q <= 1'b0;
			test_q <= 1'b0;
			arm_q <= 1'b0;
			last_toggle_q <= '0;
			fire_end_q <= '0;
			phase_start_q <= '0;
			phase_q <= PH_IDLE;
			verdict_q <= RC_PASSED;
		end else if (go) begin
			fire_q <= fire_d;
			test_q <= test_d;
			arm_q <= arm_d;
			last_toggle_q <= last_toggle_d;
			fire_end_q <= fire_end_d;
			phase_start_q <= phase_start_d;
			phase_q <= phase_d;
			verdict_q <= verdict_d;
		end
	end

endmodule

// ===== design/pyro_release_fire_and_selftest.sv =====
// ----------------------------------------------------------------------------
// Release actuator controller
// Top level: request register, control state and result register.
// ----------------------------------------------------------------------------
// One request is accepted every clock cycle when the result side keeps up.
// A request is captured in an input register, evaluated against the drive
// levels, timers and self-test state in a single pass of logic, and its
// result is registered and offered on the output from the result register.
// The state update for each request happens as it moves into the result
// register, giving one request per clock while the result side keeps up.
// ----------------------------------------------------------------------------
module pyro_release_fire_and_selftest (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  pyro_pkg::req_t in_req,
	output logic           out_valid,
	input  logic           out_stall,
	output pyro_pkg::res_t out_res,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	import pyro_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	res_t res_d;
	res_t res_s2;
	logic valid_s2;
	logic advance;
	logic go;

	assign advance = !valid_s2 || !out_stall;
	assign go = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	pyro_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pyro_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) req_s1 <= in_req;
		if (go) res_s2 <= res_d;
	end

	assign out_valid = valid_s2;
	assign out_res = res_s2;

endmodule

// ===== design/pyro_checker.sv =====
// ----------------------------------------------------------------------------
// Release actuator port checker
// Watches the top-level ports over time and flags inconsistent behaviour.
// ----------------------------------------------------------------------------
module pyro_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input pyro_pkg::req_t in_req,
	input logic           out_valid,
	input logic           out_stall,
	input pyro_pkg::res_t out_res,
	input logic           cfg_we,
	input logic [2:0]     cfg_index,
	input logic [31:0]    cfg_data
);
	import pyro_pkg::*;

	logic unused_ok;
	assign unused_ok = ^{in_valid, in_req, cfg_we, cfg_index, cfg_data};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_res))
		else $error("result changed while stalled");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the result side was free");

	a_fault_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.armed_in_test_fault |-> !out_res.done_or_accepted &&
		out_res.result_code == RC_RUNNING)
		else $error("armed fault reported alongside another outcome");

	a_done_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.done_or_accepted |-> out_res.result_code == RC_RUNNING)
		else $error("completion reported with a test result code");

endmodule

bind pyro_release_fire_and_selftest pyro_checker u_pyro_checker (.*);

// ===== sim/pyro_release_checker.sv =====
// ----------------------------------------------------------------------------
// Release actuator controller checker
// Watches the request, result and register ports of the controller. Each
// accepted request is run through an independent model of the drive levels,
// fire timers and self-test sequence. Every accepted result is compared
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pyro_release_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  pyro_pkg::req_t in_req,
	input  logic           out_valid,
	input  logic           out_stall,
	input  pyro_pkg::res_t out_res,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	output int             errors,
	output int             pending
);
	import pyro_pkg::*;

	cfg_t       cfg;
	logic       fire_lv;
	logic       test_lv;
	logic       arm_lv;
	time_t      toggle_at;
	time_t      fire_end;
	time_t      phase_t0;
	logic [2:0] phase;
	logic [2:0] verdict;
	res_t       res_due[$];
	res_t       predicted;
	res_t       oldest;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic logic reached(input time_t a, input time_t b);
		time_t d;
		d = a - b;
		return !d[TIME_BITS-1];
	endfunction

	task automatic pulse_fire(input logic [31:0] code, input time_t now);
		time_t since;
		since = now - toggle_at;
		if (code == cfg.expected_code && since >= time_t'(cfg.half_period_cycles)) begin
			toggle_at = now;
			fire_lv = ~fire_lv;
		end
	endtask

	task automatic advance_selftest(input req_t r, output logic [2:0] rc, output logic fault);
		time_t      due;
		logic [2:0] ph;
		due = phase_t0 + time_t'(cfg.settle_delay_cycles);
		ph = (phase > PH_FIRE_OFF) ? PH_IDLE : phase;
		rc = RC_RUNNING;
		fault = 1'b0;
		if (ph != PH_IDLE && r.arm_sense) begin
			fault = 1'b1;
		end else begin
			case (ph)
			PH_TEST_WAIT: begin
				if (reached(r.now, due)) begin
					if (r.test_volt_mv < cfg.no_battery_mv) verdict = RC_NO_BATTERY;
					else if (r.test_volt_mv < cfg.low_battery_mv) verdict = RC_LOW_BATTERY;
					else if (r.arm_volt_mv < ARM_SHORT_MV) verdict = RC_SHORT;
					phase = (verdict != RC_PASSED) ? PH_FIRE_OFF : PH_FIRE_WAIT;
				end
			end
			PH_FIRE_WAIT: begin
				pulse_fire(cfg.expected_code, r.now);
				if (r.fire_monitor) begin
					phase = PH_FIRE_ON;
					phase_t0 = r.now;
				end
			end
			PH_FIRE_ON: begin
				pulse_fire(cfg.expected_code, r.now);
				if (reached(r.now, due)) begin
					if (r.release_volt_mv > cfg.fail_open_mv) verdict = RC_OPEN;
					else if (r.arm_volt_mv > cfg.no_release_test_mv) verdict = RC_NO_RELEASE;
					phase = PH_OFF_WAIT;
				end
			end
			PH_OFF_WAIT: begin
				if (!r.fire_monitor) begin
					phase = PH_FIRE_OFF;
					phase_t0 = r.now;
				end
			end
			PH_FIRE_OFF: begin
				if (reached(r.now, due)) begin
					test_lv = 1'b0;
					phase = PH_IDLE;
					rc = verdict;
				end
			end
			default: begin
				phase = PH_IDLE;
				if (!r.arm_sense) begin
					test_lv = 1'b1;
					phase = PH_TEST_WAIT;
					phase_t0 = r.now;
					verdict = RC_PASSED;
				end
			end
			endcase
		end
	endtask

	task automatic predict_outcome(input req_t r, output res_t e);
		e = '0;
		case (r.func)
		FN_FIRE: begin
			if (!r.fire_monitor) begin
				fire_end = r.now + time_t'(cfg.fire_hold_cycles);
				pulse_fire(r.offered_code, r.now);
			end else if (reached(r.now, fire_end)) begin
				fire_lv = 1'b0;
				e.done_or_accepted = 1'b1;
			end else begin
				pulse_fire(r.offered_code, r.now);
			end
		end
		FN_SELFTEST: advance_selftest(r, e.result_code, e.armed_in_test_fault);
		FN_ARM: begin
			if (!test_lv) begin
				arm_lv = 1'b1;
				e.done_or_accepted = 1'b1;
			end
		end
		FN_DISARM: begin
			if (!r.fire_monitor) begin
				arm_lv = 1'b0;
				e.done_or_accepted = 1'b1;
			end
		end
		FN_STATUS: begin
			e.result_code = RC_PASSED;
			if (r.fire_monitor) begin
				if (r.release_volt_mv > cfg.fail_open_mv) e.result_code = RC_OPEN;
				else if (r.arm_volt_mv > ARMED_NO_RELEASE_MV) e.result_code = RC_NO_RELEASE;
			end else begin
				if (r.arm_volt_mv < cfg.no_battery_mv) e.result_code = RC_NO_BATTERY;
				else if (r.arm_volt_mv < cfg.low_battery_mv) e.result_code = RC_LOW_BATTERY;
			end
		end
		default: ;
		endcase
		e.fire_drive = fire_lv;
		e.test_drive = test_lv;
		e.arm_drive = arm_lv;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.expected_code = '0;
			cfg.half_period_cycles = 31'd200;
			cfg.fire_hold_cycles = 31'd3000000;
			cfg.settle_delay_cycles = 31'd100000;
			cfg.no_battery_mv = 16'd5000;
			cfg.low_battery_mv = 16'd24000;
			cfg.fail_open_mv = 16'd500;
			cfg.no_release_test_mv = 16'd1000;
			fire_lv = 1'b0;
			test_lv = 1'b0;
			arm_lv = 1'b0;
			toggle_at = '0;
			fire_end = '0;
			phase = PH_IDLE;
			phase_t0 = '0;
			verdict = RC_PASSED;
			res_due.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_EXPECTED_CODE: cfg.expected_code = cfg_data;
				REG_HALF_PERIOD:   cfg.half_period_cycles = cfg_data[PERIOD_W-1:0];
				REG_FIRE_HOLD:     cfg.fire_hold_cycles = cfg_data[PERIOD_W-1:0];
				REG_SETTLE_DELAY:  cfg.settle_delay_cycles = cfg_data[PERIOD_W-1:0];
				REG_NO_BATTERY:    cfg.no_battery_mv = cfg_data[15:0];
				REG_LOW_BATTERY:   cfg.low_battery_mv = cfg_data[15:0];
				REG_FAIL_OPEN:     cfg.fail_open_mv = cfg_data[15:0];
				REG_NO_RELEASE:    cfg.no_release_test_mv = cfg_data[15:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_outcome(in_req, predicted);
				res_due.push_back(predicted);
			end
			if (out_valid && !out_stall) begin
				if (res_due.size() == 0) begin
					flag_mismatch("result with no request outstanding", 32'(out_res), 0);
				end else begin
					oldest = res_due.pop_front();
					if (out_res.done_or_accepted !== oldest.done_or_accepted)
						flag_mismatch("done_or_accepted", 32'(out_res.done_or_accepted),
							32'(oldest.done_or_accepted));
					if (out_res.result_code !== oldest.result_code)
						flag_mismatch("result_code", 32'(out_res.result_code),
							32'(oldest.result_code));
					if (out_res.fire_drive !== oldest.fire_drive)
						flag_mismatch("fire_drive", 32'(out_res.fire_drive),
							32'(oldest.fire_drive));
					if (out_res.test_drive !== oldest.test_drive)
						flag_mismatch("test_drive", 32'(out_res.test_drive),
							32'(oldest.test_drive));
					if (out_res.arm_drive !== oldest.arm_drive)
						flag_mismatch("arm_drive", 32'(out_res.arm_drive),
							32'(oldest.arm_drive));
					if (out_res.armed_in_test_fault !== oldest.armed_in_test_fault)
						flag_mismatch("armed_in_test_fault", 32'(out_res.armed_in_test_fault),
							32'(oldest.armed_in_test_fault));
				end
			end
			pending <= res_due.size();
		end
	end

endmodule

// ===== sim/pyro_release_fire_and_selftest_test.sv =====
// ----------------------------------------------------------------------------
// Release actuator controller testbench
// Drives directed and random requests through the controller under several
// register settings and idling patterns, including a long result hold-off
// that fills the block. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module pyro_release_fire_and_selftest_test;
	import pyro_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	req_t        in_req;
	logic        out_valid;
	logic        out_stall;
	res_t        out_res;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;

	time_t       stamp;
	logic [31:0] code_now;
	logic [15:0] lb_mv;
	logic [15:0] fo_mv;
	logic [15:0] nr_mv;
	int unsigned step_max;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_asks = 0;
	int          items_done;

	pyro_release_fire_and_selftest dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pyro_release_checker release_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

	// The result side stalls at random, or holds off completely for a long
	// stretch when asked, while the request side keeps offering.
	initial begin
		int holds_seen;
		holds_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_seen) begin
				holds_seen = hold_asks;
				out_stall <= 1'b1;
				repeat (60) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic issue(input logic [2:0] f, input time_t t, input logic [31:0] code,
			input logic mon, input logic arm, input logic [15:0] vt, input logic [15:0] va,
			input logic [15:0] vr);
		req_t r;
		int   gap;
		r.func = f;
		r.now = t;
		r.offered_code = code;
		r.fire_monitor = mon;
		r.arm_sense = arm;
		r.test_volt_mv = vt;
		r.arm_volt_mv = va;
		r.release_volt_mv = vr;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic offer(input logic [2:0] f, input logic mon, input logic arm,
			input logic [31:0] code);
		logic [15:0] vt;
		logic [15:0] va;
		logic [15:0] vr;
		vt = ($urandom_range(3) != 0) ? 16'($urandom_range(16'hFFFF, lb_mv)) : 16'($urandom);
		case ($urandom_range(2))
		0: va = 16'($urandom_range(nr_mv));
		1: va = 16'($urandom_range(30000, ARM_SHORT_MV));
		default: va = 16'($urandom);
		endcase
		vr = ($urandom_range(9) < 7) ? 16'($urandom_range(fo_mv)) : 16'($urandom);
		issue(f, stamp, code, mon, arm, vt, va, vr);
		stamp = stamp + time_t'($urandom_range(step_max));
		items_done++;
	endtask

	function automatic logic [31:0] fire_code();
		return ($urandom_range(99) < 85) ? code_now : $urandom;
	endfunction

	task automatic write_reg(input cfg_reg_t k, input logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= k;
		cfg_data <= d;
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [31:0] code, input logic [30:0] half,
			input logic [30:0] hold, input logic [30:0] delay, input logic [15:0] nb,
			input logic [15:0] lb, input logic [15:0] fo, input logic [15:0] nr);
		write_reg(REG_EXPECTED_CODE, code);
		write_reg(REG_HALF_PERIOD, {1'($urandom_range(1)), half});
		write_reg(REG_FIRE_HOLD, {1'($urandom_range(1)), hold});
		write_reg(REG_SETTLE_DELAY, {1'($urandom_range(1)), delay});
		write_reg(REG_NO_BATTERY, {16'($urandom), nb});
		write_reg(REG_LOW_BATTERY, {16'($urandom), lb});
		write_reg(REG_FAIL_OPEN, {16'($urandom), fo});
		write_reg(REG_NO_RELEASE, {16'($urandom), nr});
		cfg_we <= 1'b0;
		code_now = code;
		lb_mv = lb;
		fo_mv = fo;
		nr_mv = nr;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic run_phase(input logic [31:0] code, input logic [30:0] half,
			input logic [30:0] hold, input logic [30:0] delay, input logic [15:0] nb,
			input logic [15:0] lb, input logic [15:0] fo, input logic [15:0] nr,
			input int unsigned step, input int snd, input int stl, input bit squeeze);
		int         first;
		int         n;
		int         a;
		int         b;
		int         pick;
		logic [2:0] f;
		drain();
		set_regs(code, half, hold, delay, nb, lb, fo, nr);
		step_max = step;
		send_idle_pct = snd;
		stall_pct = stl;
		if (squeeze) hold_asks++;
		first = items_done;
		while (items_done - first < 65) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				// A whole self-test run: monitor low, then high while firing, then low.
				n = $urandom_range(24, 8);
				a = $urandom_range(n / 2, 2);
				b = $urandom_range(n - 1, a + 1);
				for (int i = 0; i < n; i++)
					offer(FN_SELFTEST, i >= a && i < b, $urandom_range(19) == 0, $urandom);
			end else if (pick < 65) begin
				n = $urandom_range(16, 4);
				a = $urandom_range(n);
				for (int i = 0; i < n; i++)
					offer(FN_FIRE, i >= a, 1'($urandom_range(1)), fire_code());
			end else if (pick < 85) begin
				offer(3'($urandom_range(FN_STATUS, FN_ARM)), 1'($urandom_range(1)),
					1'($urandom_range(1)), $urandom);
			end else begin
				f = 3'($urandom_range(7));
				issue(f, $urandom, ($urandom_range(1) != 0) ? code_now : $urandom,
					1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
					16'($urandom), 16'($urandom));
				if (f <= FN_STATUS) items_done++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_we = 1'b0;
		cfg_index = REG_EXPECTED_CODE;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		items_done = 0;
		stamp = '0;
		step_max = 1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_regs(32'hC0DE_F00D, 31'd3, 31'd8, 31'd5, 16'd5000, 16'd24000, 16'd500, 16'd1000);
		issue(FN_STATUS, 32'd100, '0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_STATUS, 32'd101, '0, 1'b0, 1'b0, 16'd0, 16'd10000, 16'd0);
		issue(FN_STATUS, 32'd102, '0, 1'b1, 1'b0, 16'd0, 16'd0, 16'hFFFF);
		issue(FN_STATUS, 32'd103, '0, 1'b1, 1'b0, 16'd0, 16'hFFFF, 16'd0);
		issue(FN_ARM, 32'd104, '0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_DISARM, 32'd105, '0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_DISARM, 32'd106, '0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_FIRE, 32'd1000, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_FIRE, 32'd1001, 32'hC0DE_F00D, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_FIRE, 32'd1002, 32'hC0DE_F00D, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_FIRE, 32'd1004, 32'hC0DE_F00D, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_FIRE, 32'd1010, 32'hC0DE_F00D, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
		// A full self-test that passes, with an arm attempt and an armed poll mid-way.
		issue(FN_SELFTEST, 32'd2000, '0, 1'b0, 1'b0, 16'd30000, 16'd6000, 16'd0);
		issue(FN_ARM, 32'd2001, '0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_SELFTEST, 32'd2005, '0, 1'b0, 1'b0, 16'd30000, 16'd6000, 16'd0);
		issue(FN_SELFTEST, 32'd2006, '0, 1'b1, 1'b0, 16'd30000, 16'd6000, 16'd0);
		issue(FN_SELFTEST, 32'd2007, '0, 1'b1, 1'b1, 16'd30000, 16'd6000, 16'd0);
		issue(FN_SELFTEST, 32'd2011, '0, 1'b1, 1'b0, 16'd30000, 16'd0, 16'd0);
		issue(FN_SELFTEST, 32'd2012, '0, 1'b0, 1'b0, 16'd30000, 16'd0, 16'd0);
		issue(FN_SELFTEST, 32'd2017, '0, 1'b0, 1'b0, 16'd30000, 16'd0, 16'd0);
		// An early failure skips straight to the last phase and ends on the next poll.
		issue(FN_SELFTEST, 32'd3000, '0, 1'b0, 1'b0, 16'd30000, 16'd6000, 16'd0);
		issue(FN_SELFTEST, 32'd3005, '0, 1'b0, 1'b0, 16'd0, 16'd6000, 16'd0);
		issue(FN_SELFTEST, 32'd3006, '0, 1'b0, 1'b0, 16'd0, 16'd6000, 16'd0);
		issue(3'($urandom_range(7, 5)), 32'd3007, '0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		issue(FN_FIRE, 32'hFFFF_FFFF, 32'hC0DE_F00D, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
		issue(FN_FIRE, 32'h0000_0007, 32'hC0DE_F00D, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
		stamp = 32'd4000;

		run_phase($urandom, 31'd1, 31'd1, 31'd1, 16'd5000, 16'd24000, 16'd500, 16'd1000,
			3, 0, 0, 1'b0);
		run_phase(32'd0, 31'd0, 31'd20, 31'd8, 16'd0, 16'd0, 16'd0, 16'd0,
			4, 46, 0, 1'b0);
		run_phase(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h4000_0000, 0, 46, 1'b0);
		run_phase($urandom, 31'($urandom_range(6, 1)), 31'($urandom_range(40, 4)),
			31'($urandom_range(15, 2)), 16'($urandom_range(8000)),
			16'($urandom_range(30000, 8000)), 16'($urandom_range(2000)),
			16'($urandom_range(3000)), 6, 10, 10, 1'b0);
		run_phase(32'h1234_5678, 31'd200, 31'd3000, 31'd100, 16'd5000, 16'd24000, 16'd500,
			16'd1000, 120, 0, 0, 1'b1);
		run_phase($urandom, 31'($urandom_range(10, 1)), 31'($urandom_range(60, 1)),
			31'($urandom_range(20, 1)), 16'($urandom_range(8000)),
			16'($urandom_range(30000)), 16'($urandom_range(2000)),
			16'($urandom_range(3000)), 10, 46, 0, 1'b0);

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
